[src/lqvp_pkg.sv]
package lqvp_pkg;

	localparam int DATA_W = 32;
	localparam int OCC_W  = 8;

	typedef enum logic [1:0] {
		CMD_ENQ   = 2'd0,
		CMD_DEQ   = 2'd1,
		CMD_PURGE = 2'd2
	} lqvp_cmd_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic signed [DATA_W-1:0] RD_EMPTY = -32'sd1;

	typedef struct packed {
		logic [1:0]               command;
		logic signed [DATA_W-1:0] value;
	} lqvp_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_data;
		logic [1:0]               status;
		logic [OCC_W-1:0]         occupancy;
	} lqvp_rsp_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DEQ,
		S_PURGE,
		S_PDRAIN
	} lqvp_state_t;

endpackage

[src/linear_queue_with_value_purge.sv]
// channel | direction | handshake              | payload
// req     | in        | req_valid / req_ready  | lqvp_req_t (command, value)
// rsp     | out       | rsp_valid / rsp_ready  | lqvp_rsp_t (read_data, status, occupancy)
//
// enqueue, refused or ignored commands, empty purge: result registered on transfer
// dequeue: registered slot memory read port, then the result register
// purge: slots head to tail, one slot read per cycle through the same port
// one command in flight; req_ready drops while a dequeue or purge is in progress
// req_ready also waits for the result register to empty or be taken in the same cycle
// arst_n clears indices, empty flag and control; slot memory is not cleared
module linear_queue_with_value_purge
	import lqvp_pkg::*;
#(
	parameter int DEPTH = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  lqvp_req_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output lqvp_rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	lqvp_state_t state_q, state_d;

	logic [AW-1:0]     head_q, tail_q;
	logic              empty_q;
	logic              rsp_valid_q;
	lqvp_rsp_t         rsp_q;
	logic [AW-1:0]     rd_ptr_q;
	logic [AW-1:0]     rd_ptr_s1;
	logic              pv_s1;
	logic [AW:0]       wr_cnt_q;
	logic [DATA_W-1:0] key_q;

	logic              req_fire;
	logic              full;
	logic [AW-1:0]     nx_head, nx_tail;
	logic              nx_empty;
	logic [1:0]        res_status;
	logic [DATA_W-1:0] res_data;
	logic              go_deq, go_purge, enq_wr;
	logic [AW:0]       held_next;
	logic              keep;
	logic [AW:0]       w_next;
	logic              rsp_set;

	logic              ram_wr_en, ram_rd_en;
	logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
	logic [DATA_W-1:0] ram_wr_data, ram_rd_data;

	lqvp_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign req_fire = req_valid && req_ready;
	assign full     = !empty_q && (tail_q == LAST);

	// command decode for the idle state
	always_comb begin
		nx_head    = head_q;
		nx_tail    = tail_q;
		nx_empty   = empty_q;
		res_status = ST_OK;
		res_data   = '0;
		go_deq     = 1'b0;
		go_purge   = 1'b0;
		enq_wr     = 1'b0;
		case (req.command)
			CMD_ENQ: begin
				if (empty_q) begin
					nx_head  = '0;
					nx_tail  = '0;
					nx_empty = 1'b0;
					enq_wr   = 1'b1;
				end else if (full) begin
					res_status = ST_FULL;
				end else begin
					nx_tail = tail_q + 1'b1;
					enq_wr  = 1'b1;
				end
			end
			CMD_DEQ: begin
				if (empty_q) begin
					res_data   = RD_EMPTY;
					res_status = ST_EMPTY;
				end else begin
					go_deq = 1'b1;
					if (head_q >= tail_q) begin
						nx_empty = 1'b1;
						nx_head  = '0;
						nx_tail  = '0;
					end else begin
						nx_head = head_q + 1'b1;
					end
				end
			end
			CMD_PURGE: begin
				go_purge = !empty_q;
			end
			default: begin
			end
		endcase
	end

	assign held_next = nx_empty ? '0 : ({1'b0, nx_tail} - {1'b0, nx_head} + 1'b1);

	// purge compaction: survivor count including the word now at the read port
	assign keep   = pv_s1 && (ram_rd_data != key_q);
	assign w_next = wr_cnt_q + {{AW{1'b0}}, keep};

	// result becomes valid on an immediate command, after the dequeue read or at purge end
	assign rsp_set = ((state_q == S_IDLE) && req_fire && !go_deq && !go_purge) ||
		(state_q == S_DEQ) || (state_q == S_PDRAIN);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire && go_deq) begin
					state_d = S_DEQ;
				end else if (req_fire && go_purge) begin
					state_d = S_PURGE;
				end
			end
			S_DEQ: begin
				state_d = S_IDLE;
			end
			S_PURGE: begin
				if (rd_ptr_q == tail_q) begin
					state_d = S_PDRAIN;
				end
			end
			S_PDRAIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs and memory controls
	// purge writes land at or below the slot being written back, reads run ahead of them,
	// so a read never meets a pending write to the same slot
	always_comb begin
		req_ready   = 1'b0;
		ram_rd_en   = 1'b0;
		ram_rd_addr = head_q;
		ram_wr_en   = 1'b0;
		ram_wr_addr = empty_q ? '0 : tail_q + 1'b1;
		ram_wr_data = req.value;
		case (state_q)
			S_IDLE: begin
				req_ready = !rsp_valid_q || rsp_ready;
				ram_rd_en = req_fire && go_deq;
				ram_wr_en = req_fire && enq_wr;
			end
			S_DEQ: begin
			end
			S_PURGE, S_PDRAIN: begin
				ram_rd_en   = (state_q == S_PURGE);
				ram_rd_addr = rd_ptr_q;
				ram_wr_en   = keep;
				ram_wr_addr = wr_cnt_q[AW-1:0];
				ram_wr_data = ram_rd_data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			empty_q     <= 1'b1;
			rsp_valid_q <= 1'b0;
			pv_s1       <= 1'b0;
			rd_ptr_q    <= '0;
			wr_cnt_q    <= '0;
		end else begin
			state_q     <= state_d;
			pv_s1       <= (state_q == S_PURGE);
			rsp_valid_q <= rsp_set || (rsp_valid_q && !rsp_ready);
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						head_q  <= nx_head;
						tail_q  <= nx_tail;
						empty_q <= nx_empty;
						rd_ptr_q <= head_q;
						wr_cnt_q <= '0;
					end
				end
				S_DEQ: begin
				end
				S_PURGE: begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
					wr_cnt_q <= w_next;
				end
				S_PDRAIN: begin
					head_q      <= '0;
					tail_q      <= (w_next == '0) ? '0 : AW'(w_next - 1'b1);
					empty_q     <= (w_next == '0);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_ptr_s1 <= rd_ptr_q;
		if (req_fire) begin
			key_q               <= req.value;
			rsp_q.read_data     <= res_data;
			rsp_q.status        <= res_status;
			rsp_q.occupancy     <= OCC_W'(held_next);
		end else if (state_q == S_DEQ) begin
			rsp_q.read_data     <= ram_rd_data;
		end else if (state_q == S_PDRAIN) begin
			rsp_q.read_data     <= '0;
			rsp_q.status        <= ST_OK;
			rsp_q.occupancy     <= OCC_W'(w_next);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (head_q == '0) && (tail_q == '0))
		else $error("empty queue with nonzero index");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		!empty_q |-> head_q <= tail_q)
		else $error("head beyond tail");

	a_wr_behind: assert property (@(posedge clk) disable iff (!arst_n)
		pv_s1 |-> wr_cnt_q <= {1'b0, rd_ptr_s1})
		else $error("purge write overtook read");

	a_busy_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !rsp_valid_q)
		else $error("result pending during dequeue or purge");
`endif

endmodule

[src/lqvp_ram.sv]
module lqvp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import lqvp_pkg::*;

	localparam int DEPTH      = 128;
	localparam int DIR_N      = 25;
	localparam int RAND_ITEMS = 1700;
	localparam int LIMIT      = 1000000;
	localparam int END_PAUSE  = 300;
	localparam int MAX_PRINTS = 40;

	// the command code the block ignores
	localparam logic [1:0] CMD_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [DATA_W-1:0] value;
		logic              fixed;
		logic [DATA_W-1:0] rd;
		logic [1:0]        st;
		logic [OCC_W-1:0]  occ;
	} dir_row_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	lqvp_req_t req       = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	lqvp_rsp_t rsp;

	linear_queue_with_value_purge #(
		.DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #6 clk = ~clk;

	// directed rows: fixed results only where they are obvious from the start state
	dir_row_t dir_table [DIR_N] = '{
		'{CMD_DEQ,   32'h0000_0000, 1'b1, RD_EMPTY,      ST_EMPTY, 8'd0},
		'{CMD_PURGE, 32'h0000_0005, 1'b1, 32'h0,         ST_OK,    8'd0},
		'{CMD_NONE,  32'hffff_ffff, 1'b1, 32'h0,         ST_OK,    8'd0},
		'{CMD_ENQ,   32'h7fff_ffff, 1'b1, 32'h0,         ST_OK,    8'd1},
		'{CMD_ENQ,   32'h8000_0000, 1'b1, 32'h0,         ST_OK,    8'd2},
		'{CMD_ENQ,   32'hffff_ffff, 1'b1, 32'h0,         ST_OK,    8'd3},
		'{CMD_ENQ,   32'h0000_0000, 1'b1, 32'h0,         ST_OK,    8'd4},
		'{CMD_ENQ,   32'h7fff_ffff, 1'b1, 32'h0,         ST_OK,    8'd5},
		'{CMD_DEQ,   32'hffff_ffff, 1'b1, 32'h7fff_ffff, ST_OK,    8'd4},
		'{CMD_PURGE, 32'hffff_ffff, 1'b0, 32'h0,         ST_OK,    8'd0},
		'{CMD_NONE,  32'h0000_0000, 1'b0, 32'h0,         ST_OK,    8'd0},
		'{CMD_ENQ,   32'h5555_5555, 1'b0, 32'h0,         ST_OK,    8'd0},
		'{CMD_ENQ,   32'haaaa_aaaa, 1'b0, 32'h0,         ST_OK,    8'd0},
		'{CMD_PURGE, 32'h7fff_ffff, 1'b0, 32'h0,         ST_OK,    8'd0},
		'{CMD_DEQ,   32'h0000_0000, 1'b0, 32'h0,         ST_OK,    8'd0},
		'{CMD_PURGE, 32'h0000_0000, 1'b0, 32'h0,         ST_OK,    8'd0},
		'{CMD_DEQ,   32'h0000_0000, 1'b0, 32'h0,         ST_OK,    8'd0},
		'{CMD_DEQ,   32'h0000_0000, 1'b0, 32'h0,         ST_OK,    8'd0},
		'{CMD_ENQ,   32'h0000_0003, 1'b0, 32'h0,         ST_OK,    8'd0},
		'{CMD_ENQ,   32'h0000_0003, 1'b0, 32'h0,         ST_OK,    8'd0},
		'{CMD_ENQ,   32'h0000_0003, 1'b0, 32'h0,         ST_OK,    8'd0},
		'{CMD_PURGE, 32'h0000_0003, 1'b0, 32'h0,         ST_OK,    8'd0},
		'{CMD_DEQ,   32'h0000_0000, 1'b0, 32'h0,         ST_OK,    8'd0},
		'{CMD_ENQ,   32'hffff_fffe, 1'b0, 32'h0,         ST_OK,    8'd0},
		'{CMD_PURGE, 32'h0000_0009, 1'b0, 32'h0,         ST_OK,    8'd0}
	};

	lqvp_req_t cmd_list [$];
	logic      cmd_fixed [$];
	lqvp_rsp_t cmd_fixed_rsp [$];
	lqvp_rsp_t rsp_expected [$];
	int        cmd_total;
	int        accepted_n;
	int        err_n;

	// own copy of the queue contents
	logic [DATA_W-1:0] q_mem [DEPTH];
	int unsigned       q_head;
	int unsigned       q_tail;
	logic              q_empty;

	function automatic lqvp_rsp_t queue_model_step(input lqvp_req_t r);
		lqvp_rsp_t   o;
		int unsigned w;
		int unsigned i;
		int unsigned held;
		o = '0;
		case (r.command)
			CMD_ENQ: begin
				if (q_empty) begin
					q_head  = 0;
					q_tail  = 0;
					q_mem[0] = r.value;
					q_empty = 1'b0;
				end else if (q_tail >= DEPTH - 1) begin
					o.status = ST_FULL;
				end else begin
					q_tail = q_tail + 1;
					q_mem[q_tail] = r.value;
				end
			end
			CMD_DEQ: begin
				if (q_empty) begin
					o.read_data = RD_EMPTY;
					o.status    = ST_EMPTY;
				end else begin
					o.read_data = q_mem[q_head];
					if (q_head >= q_tail) begin
						q_empty = 1'b1;
						q_head  = 0;
						q_tail  = 0;
					end else begin
						q_head = q_head + 1;
					end
				end
			end
			CMD_PURGE: begin
				if (!q_empty) begin
					w = 0;
					for (i = q_head; i <= q_tail; i++) begin
						if (q_mem[i] != r.value) begin
							q_mem[w] = q_mem[i];
							w++;
						end
					end
					if (w == 0) begin
						q_empty = 1'b1;
						q_head  = 0;
						q_tail  = 0;
					end else begin
						q_head = 0;
						q_tail = w - 1;
					end
				end
			end
			default: ;
		endcase
		held = q_empty ? 0 : q_tail - q_head + 1;
		o.occupancy = held[OCC_W-1:0];
		return o;
	endfunction

	// small pool so that purges find matches
	function automatic logic [DATA_W-1:0] pick_value();
		if ($urandom_range(0, 9) < 6) begin
			case ($urandom_range(0, 7))
				0: return 32'h0000_0000;
				1: return 32'hffff_ffff;
				2: return 32'h7fff_ffff;
				3: return 32'h8000_0000;
				4: return 32'h0000_0001;
				5: return 32'h0000_0002;
				6: return 32'h5a5a_5a5a;
				default: return 32'ha5a5_a5a5;
			endcase
		end
		return $urandom;
	endfunction

	task automatic add_cmd(input logic [1:0] c, input logic [DATA_W-1:0] v);
		lqvp_req_t r;
		r.command = c;
		r.value   = v;
		cmd_list.push_back(r);
		cmd_fixed.push_back(1'b0);
		cmd_fixed_rsp.push_back('0);
	endtask

	// sender: bursts of random length with random gaps
	int send_idx   = 0;
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else if (!req_valid || req_ready) begin
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (send_idx < cmd_total) begin
				req_valid <= 1'b1;
				req       <= cmd_list[send_idx];
				send_idx++;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// receiver: stall pattern re-chosen at random among four modes
	int stall_cyc  = 0;
	int stall_mode = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			stall_cyc++;
			case (stall_mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= (stall_cyc % 7) < 4;
				2: rsp_ready <= ($urandom_range(0, 3) != 0);
				default: rsp_ready <= (stall_cyc % 32) >= 20;
			endcase
			if (stall_cyc % 300 == 0)
				stall_mode = $urandom_range(0, 3);
		end
	end

	// transfer monitor: predict on request, compare on result
	always @(posedge clk) begin
		lqvp_rsp_t p;
		lqvp_rsp_t e;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				p = queue_model_step(req);
				if (cmd_fixed[accepted_n])
					p = cmd_fixed_rsp[accepted_n];
				rsp_expected.push_back(p);
				accepted_n++;
			end
			if (rsp_valid && rsp_ready) begin
				if (rsp_expected.size() == 0) begin
					if (err_n < MAX_PRINTS)
						$display("%0t unexpected result: read_data %0d status %0d occupancy %0d",
							$time, $signed(rsp.read_data), rsp.status, rsp.occupancy);
					err_n++;
				end else begin
					e = rsp_expected.pop_front();
					if (rsp.read_data !== e.read_data) begin
						if (err_n < MAX_PRINTS)
							$display("%0t read_data mismatch: expected %0d actual %0d",
								$time, $signed(e.read_data), $signed(rsp.read_data));
						err_n++;
					end
					if (rsp.status !== e.status) begin
						if (err_n < MAX_PRINTS)
							$display("%0t status mismatch: expected %0d actual %0d",
								$time, e.status, rsp.status);
						err_n++;
					end
					if (rsp.occupancy !== e.occupancy) begin
						if (err_n < MAX_PRINTS)
							$display("%0t occupancy mismatch: expected %0d actual %0d",
								$time, e.occupancy, rsp.occupancy);
						err_n++;
					end
				end
			end
		end
	end

	initial begin
		int cyc;
		cyc = 0;
		while (cyc < LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		lqvp_req_t r;
		lqvp_rsp_t f;
		int        i;
		int        kind;
		int        len;
		int        pick;
		accepted_n = 0;
		err_n      = 0;
		q_empty    = 1'b1;
		q_head     = 0;
		q_tail     = 0;
		for (i = 0; i < DIR_N; i++) begin
			r.command   = dir_table[i].cmd;
			r.value     = dir_table[i].value;
			f.read_data = dir_table[i].rd;
			f.status    = dir_table[i].st;
			f.occupancy = dir_table[i].occ;
			cmd_list.push_back(r);
			cmd_fixed.push_back(dir_table[i].fixed);
			cmd_fixed_rsp.push_back(f);
		end
		// episodes: fill to the end slot, drain past empty, mixed traffic, purge runs
		while (cmd_list.size() < DIR_N + RAND_ITEMS) begin
			kind = $urandom_range(0, 9);
			if (kind < 2) begin
				repeat (DEPTH + 3) add_cmd(CMD_ENQ, pick_value());
			end else if (kind < 4) begin
				repeat (DEPTH + 3) add_cmd(CMD_DEQ, $urandom);
			end else if (kind < 8) begin
				len = $urandom_range(10, 80);
				repeat (len) begin
					pick = $urandom_range(0, 99);
					if (pick < 50)
						add_cmd(CMD_ENQ, pick_value());
					else if (pick < 80)
						add_cmd(CMD_DEQ, $urandom);
					else if (pick < 95)
						add_cmd(CMD_PURGE, pick_value());
					else
						add_cmd(CMD_NONE, $urandom);
				end
			end else begin
				len = $urandom_range(5, 20);
				repeat (len) begin
					if ($urandom_range(0, 1) == 0)
						add_cmd(CMD_PURGE, pick_value());
					else
						add_cmd(CMD_ENQ, pick_value());
				end
			end
		end
		cmd_total = cmd_list.size();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (accepted_n == cmd_total);
		wait (rsp_expected.size() == 0);
		repeat (END_PAUSE) @(posedge clk);
		if (err_n == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[files.f]
src/lqvp_pkg.sv
src/lqvp_ram.sv
src/linear_queue_with_value_purge.sv
dv/tb_top.sv
